// File: src/lc3s_pkg.sv
// Shared types and constants for the LC-3 subset instruction stepper.
`timescale 1ns / 1ps

package lc3s_pkg;

   localparam int NUM_REGS      = 8;
   localparam int REG_IDX_W     = $clog2(NUM_REGS);
   localparam int QUEUE_DEPTH   = 2;
   localparam int QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W   = $clog2(QUEUE_DEPTH + 1);

   localparam logic [REG_IDX_W-1:0] TRAP_LINK_REG = REG_IDX_W'(7);

   // Standard LC-3 opcodes of the supported subset
   localparam logic [3:0] OP_BR   = 4'h0;
   localparam logic [3:0] OP_ADD  = 4'h1;
   localparam logic [3:0] OP_LD   = 4'h2;
   localparam logic [3:0] OP_ST   = 4'h3;
   localparam logic [3:0] OP_AND  = 4'h5;
   localparam logic [3:0] OP_NOT  = 4'h9;
   localparam logic [3:0] OP_JMP  = 4'hC;
   localparam logic [3:0] OP_TRAP = 4'hF;

   typedef enum logic {
      KIND_WRITE,
      KIND_STEP
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [15:0] address;
      logic [15:0] data;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } head_type;

   typedef struct packed {
      logic [15:0]          next_pc;
      logic [15:0]          instruction_word;
      logic                 reg_written;
      logic [REG_IDX_W-1:0] reg_index;
      logic [15:0]          reg_value;
      logic                 mem_written;
      logic [15:0]          mem_address;
      logic [15:0]          mem_value;
      logic [2:0]           cond_flags;
   } result_type;

endpackage

// File: src/lc3s_front.sv
// Front end: accepts requests, classifies them and queues them for the core.
`timescale 1ns / 1ps

module lc3s_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_command,
   input  logic [15:0]        req_load_address,
   input  logic [15:0]        req_load_data,
   output lc3s_pkg::head_type head,
   input  logic               pop
);
   import lc3s_pkg::*;

   item_type               entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   item_type               item_in;
   logic                   push;
   logic                   pull;

   assign req_stall = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;
   assign pull      = pop && (count_ff != '0);

   always_comb begin
      item_in.kind    = req_command ? KIND_STEP : KIND_WRITE;
      item_in.address = req_load_address;
      item_in.data    = req_load_data;
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pull) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pull) begin
         count_in = count_ff + 1'b1;
      end else if (pull && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= item_in;
      end
   end

   assign head.valid = (count_ff != '0);
   assign head.item  = entry_ff[rd_ptr_ff];

endmodule

// File: src/lc3s_core.sv
// Back end: executes queued writes and instructions against PC, registers and memory.
`timescale 1ns / 1ps

module lc3s_core #(
   parameter int MEM_WORDS = 65536
) (
   input  logic                 clock,
   input  logic                 reset,
   input  lc3s_pkg::head_type   head,
   output logic                 pop,
   input  logic                 out_free,
   output logic                 res_valid,
   output lc3s_pkg::result_type res
);
   import lc3s_pkg::*;

   localparam int AW = $clog2(MEM_WORDS);
   localparam int QW = 17 - AW;
   // Reciprocal of the memory size: exact quotient for any 16-bit address
   localparam longint unsigned RECIP = ((64'd1 << 32) + MEM_WORDS - 1) / MEM_WORDS;
   localparam int RW = $clog2(RECIP + 1);

   localparam logic [2:0] FLAG_N = 3'b100;
   localparam logic [2:0] FLAG_Z = 3'b010;
   localparam logic [2:0] FLAG_P = 3'b001;

   typedef enum logic [2:0] {
      S_IDLE,
      S_WRITE,
      S_FETCH,
      S_DECODE,
      S_MREAD,
      S_EXEC
   } state_type;

   state_type   state_ff, state_in;
   logic [15:0] pc_ff, pc_in;
   logic [2:0]  flags_ff, flags_in;
   logic [15:0] addr_ff, addr_in;
   logic [QW-1:0] quot_ff, quot_in;
   logic [15:0] data_ff, data_in;
   logic [15:0] ir_ff, ir_in;
   logic [15:0] opa_ff, opa_in;
   logic [15:0] opb_ff, opb_in;
   logic [15:0] rf_ff [NUM_REGS];
   logic [15:0] mem [MEM_WORDS];
   logic [15:0] rdata_ff;

   logic [RW-1:0]    recip;
   logic [16+RW-1:0] quot_prod;
   logic [15:0]      idx_diff;
   logic [AW-1:0]    mem_idx;
   logic             mem_we, mem_re;
   logic [15:0]      mem_wdata;
   logic             rf_we;
   logic [REG_IDX_W-1:0] rf_widx;
   logic [15:0]      rf_wdata;

   logic [3:0]  dec_op;
   logic [15:0] dec_off9;
   logic [15:0] pc_inc;
   logic [3:0]  ex_op;
   logic [REG_IDX_W-1:0] ex_dr;
   logic [15:0] ex_off9;
   logic [15:0] ex_imm5;
   logic [15:0] ex_b;
   logic [15:0] ex_r;

   function automatic logic [2:0] flags_of(input logic [15:0] r);
      logic [2:0] f;
      if (r == 16'h0000) begin
         f = FLAG_Z;
      end else if (!r[15]) begin
         f = FLAG_P;
      end else begin
         f = FLAG_N;
      end
      return f;
   endfunction

   // Address reduction modulo the memory size: quotient registered, then subtract
   assign recip     = RW'(RECIP);
   assign quot_prod = (16+RW)'(addr_in) * (16+RW)'(recip);
   assign quot_in   = QW'(quot_prod >> 32);
   assign idx_diff  = addr_ff - 16'(quot_ff * MEM_WORDS);
   assign mem_idx   = AW'(idx_diff);

   assign dec_op   = rdata_ff[15:12];
   assign dec_off9 = {{7{rdata_ff[8]}}, rdata_ff[8:0]};
   assign pc_inc   = pc_ff + 16'd1;

   assign ex_op   = ir_ff[15:12];
   assign ex_dr   = ir_ff[11:9];
   assign ex_off9 = {{7{ir_ff[8]}}, ir_ff[8:0]};
   assign ex_imm5 = {{11{ir_ff[4]}}, ir_ff[4:0]};
   assign ex_b    = ir_ff[5] ? ex_imm5 : opb_ff;

   always_comb begin
      ex_r = ~opa_ff;
      if (ex_op == OP_ADD) begin
         ex_r = opa_ff + ex_b;
      end else if (ex_op == OP_AND) begin
         ex_r = opa_ff & ex_b;
      end
   end

   always_comb begin
      state_in  = state_ff;
      pc_in     = pc_ff;
      flags_in  = flags_ff;
      addr_in   = addr_ff;
      data_in   = data_ff;
      ir_in     = ir_ff;
      opa_in    = opa_ff;
      opb_in    = opb_ff;
      pop       = 1'b0;
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      mem_wdata = data_ff;
      rf_we     = 1'b0;
      rf_widx   = ex_dr;
      rf_wdata  = ex_r;
      res_valid = 1'b0;
      res       = '0;
      case (state_ff)
         S_IDLE: begin
            if (head.valid) begin
               pop     = 1'b1;
               data_in = head.item.data;
               if (head.item.kind == KIND_STEP) begin
                  addr_in  = pc_ff;
                  state_in = S_FETCH;
               end else begin
                  addr_in  = head.item.address;
                  state_in = S_WRITE;
               end
            end
         end
         S_WRITE: begin
            if (out_free) begin
               mem_we         = 1'b1;
               res_valid      = 1'b1;
               res.next_pc    = pc_ff;
               res.cond_flags = flags_ff;
               state_in       = S_IDLE;
            end
         end
         S_FETCH: begin
            mem_re   = 1'b1;
            state_in = S_DECODE;
         end
         S_DECODE: begin
            ir_in  = rdata_ff;
            pc_in  = pc_inc;
            opa_in = rf_ff[rdata_ff[8:6]];
            opb_in = (dec_op == OP_ST) ? rf_ff[rdata_ff[11:9]] : rf_ff[rdata_ff[2:0]];
            if (dec_op == OP_TRAP) begin
               addr_in = {8'h00, rdata_ff[7:0]};
            end else begin
               addr_in = pc_inc + dec_off9;
            end
            if (dec_op == OP_LD || dec_op == OP_TRAP) begin
               state_in = S_MREAD;
            end else begin
               state_in = S_EXEC;
            end
         end
         S_MREAD: begin
            mem_re   = 1'b1;
            state_in = S_EXEC;
         end
         S_EXEC: begin
            if (out_free) begin
               res_valid            = 1'b1;
               res.instruction_word = ir_ff;
               case (ex_op)
                  OP_BR: begin
                     if ((ex_dr & flags_ff) != 3'b000) begin
                        pc_in = pc_ff + ex_off9;
                     end
                  end
                  OP_ADD, OP_AND, OP_NOT: begin
                     rf_we    = 1'b1;
                     flags_in = flags_of(ex_r);
                  end
                  OP_LD: begin
                     rf_we    = 1'b1;
                     rf_wdata = rdata_ff;
                  end
                  OP_ST: begin
                     mem_we          = 1'b1;
                     mem_wdata       = opb_ff;
                     res.mem_written = 1'b1;
                     res.mem_address = 16'(mem_idx);
                     res.mem_value   = opb_ff;
                  end
                  OP_JMP: begin
                     pc_in = opa_ff;
                  end
                  OP_TRAP: begin
                     rf_we    = 1'b1;
                     rf_widx  = TRAP_LINK_REG;
                     rf_wdata = pc_ff;
                     pc_in    = rdata_ff;
                  end
                  default: begin
                  end
               endcase
               if (rf_we) begin
                  res.reg_written = 1'b1;
                  res.reg_index   = rf_widx;
                  res.reg_value   = rf_wdata;
               end
               res.next_pc    = pc_in;
               res.cond_flags = flags_in;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pc_ff    <= '0;
         flags_ff <= FLAG_Z;
         rf_ff    <= '{default: '0};
      end else begin
         state_ff <= state_in;
         pc_ff    <= pc_in;
         flags_ff <= flags_in;
         if (rf_we) begin
            rf_ff[rf_widx] <= rf_wdata;
         end
      end
      addr_ff <= addr_in;
      quot_ff <= quot_in;
      data_ff <= data_in;
      ir_ff   <= ir_in;
      opa_ff  <= opa_in;
      opb_ff  <= opb_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_idx] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= mem[mem_idx];
      end
   end

endmodule

// File: src/lc3_subset_instruction_step.sv
// Top level of the LC-3 subset instruction stepper: front queue, core and result register.
`timescale 1ns / 1ps

//  channel | direction | handshake          | payload
//  req_    | in        | req_valid/req_stall | command, load_address, load_data
//  rsp_    | out       | rsp_valid/rsp_stall | next_pc .. cond_flags, one per request
//
// A write passes core states IDLE, WRITE; ADD, AND, NOT, BR, JMP and ST pass IDLE, FETCH,
// DECODE, EXEC; LD and TRAP add MREAD. One memory port: fetch, then a second access.
// The front queue holds two requests, so req_stall rises only when both slots are full.
// Reset clears PC, registers and the queue and sets the flags to Z; memory is not cleared.
// A stall on rsp_ holds the result register; the core waits only to hand over a result.

module lc3_subset_instruction_step #(
   parameter int MEM_WORDS = 65536
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_command,
   input  logic [15:0] req_load_address,
   input  logic [15:0] req_load_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_next_pc,
   output logic [15:0] rsp_instruction_word,
   output logic        rsp_reg_written,
   output logic [2:0]  rsp_reg_index,
   output logic [15:0] rsp_reg_value,
   output logic        rsp_mem_written,
   output logic [15:0] rsp_mem_address,
   output logic [15:0] rsp_mem_value,
   output logic [2:0]  rsp_cond_flags
);
   import lc3s_pkg::*;

   head_type   head;
   logic       pop;
   logic       out_free;
   logic       res_valid;
   result_type res;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_data_ff;

   // Front: accept and classify requests, queue them for the core
   lc3s_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_command),
      .req_load_address (req_load_address),
      .req_load_data    (req_load_data),
      .head             (head),
      .pop              (pop)
   );

   // Back: execute one queued request at a time
   lc3s_core #(
      .MEM_WORDS (MEM_WORDS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .pop       (pop),
      .out_free  (out_free),
      .res_valid (res_valid),
      .res       (res)
   );

   // Result register: free when empty or being taken this cycle
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (res_valid) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (res_valid) begin
         rsp_data_ff <= res;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_next_pc          = rsp_data_ff.next_pc;
   assign rsp_instruction_word = rsp_data_ff.instruction_word;
   assign rsp_reg_written      = rsp_data_ff.reg_written;
   assign rsp_reg_index        = rsp_data_ff.reg_index;
   assign rsp_reg_value        = rsp_data_ff.reg_value;
   assign rsp_mem_written      = rsp_data_ff.mem_written;
   assign rsp_mem_address      = rsp_data_ff.mem_address;
   assign rsp_mem_value        = rsp_data_ff.mem_value;
   assign rsp_cond_flags       = rsp_data_ff.cond_flags;

endmodule

// File: tb/lc3_subset_instruction_step_test.sv
// Self-checking bench for the LC-3 subset stepper: program feed, effect prediction, result checks.
`timescale 1ns / 1ps

module lc3_subset_instruction_step_test;
   import lc3s_pkg::*;

   // Two copies of the architectural state: PLAN runs ahead while the program
   // is built, LIVE advances only as the block takes each request.
   localparam int PLAN = 0;
   localparam int LIVE = 1;

   localparam logic [2:0] FLAG_N = 3'b100;
   localparam logic [2:0] FLAG_Z = 3'b010;
   localparam logic [2:0] FLAG_P = 3'b001;

   // Opcode 13 has no meaning in this subset; fetched and skipped.
   localparam logic [3:0] OP_UNUSED = 4'hD;

   localparam int FEED_TARGET = 1350;
   localparam int PAUSE_AT    = 700;   // sender waits here for every result
   localparam int HOLD_AT     = 300;   // receiver holds off once past this many results
   localparam int HOLD_CYCLES = 150;
   localparam int QUIET_FROM  = 900;   // no idling on either side in this window
   localparam int QUIET_TO    = 1150;
   localparam int DRAIN_WAIT  = 20;
   localparam int CYCLE_LIMIT = 200000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_command = 1'b0;
   logic [15:0] req_load_address = 16'h0000;
   logic [15:0] req_load_data = 16'h0000;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [15:0] rsp_next_pc;
   logic [15:0] rsp_instruction_word;
   logic        rsp_reg_written;
   logic [2:0]  rsp_reg_index;
   logic [15:0] rsp_reg_value;
   logic        rsp_mem_written;
   logic [15:0] rsp_mem_address;
   logic [15:0] rsp_mem_value;
   logic [2:0]  rsp_cond_flags;

   // Architectural state of both copies
   bit [15:0] word_store [2][65536];
   bit        word_loaded [65536];
   bit [15:0] pc_of [2];
   bit [15:0] gpr [2][NUM_REGS];
   bit [2:0]  nzp_of [2];

   item_type   program_feed [$];
   result_type effects_due [$];

   int  failures = 0;
   int  requests_taken = 0;
   int  results_seen = 0;
   int  cycle_count = 0;
   int  hold_left = 0;
   bit  hold_done = 1'b0;
   bit  handed_over = 1'b0;
   bit  quiet_stretch;

   assign quiet_stretch = (requests_taken >= QUIET_FROM) && (requests_taken < QUIET_TO);

   lc3_subset_instruction_step u_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_command          (req_command),
      .req_load_address     (req_load_address),
      .req_load_data        (req_load_data),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_next_pc          (rsp_next_pc),
      .rsp_instruction_word (rsp_instruction_word),
      .rsp_reg_written      (rsp_reg_written),
      .rsp_reg_index        (rsp_reg_index),
      .rsp_reg_value        (rsp_reg_value),
      .rsp_mem_written      (rsp_mem_written),
      .rsp_mem_address      (rsp_mem_address),
      .rsp_mem_value        (rsp_mem_value),
      .rsp_cond_flags       (rsp_cond_flags)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Apply one request to state copy c and return the effect it reports.
   // A write stores one word; a step fetches at PC, bumps PC and executes.
   function automatic result_type lc3_effect(int c, item_type it);
      result_type  r;
      logic [15:0] ir, off9, ea, a, b, v;
      logic [3:0]  op;
      logic [2:0]  dr, sr1, sr2;
      r = '0;
      if (it.kind == KIND_WRITE) begin
         word_store[c][it.address] = it.data;
      end else begin
         ir = word_store[c][pc_of[c]];
         pc_of[c] = pc_of[c] + 16'd1;
         op = ir[15:12];
         dr = ir[11:9];
         sr1 = ir[8:6];
         sr2 = ir[2:0];
         off9 = {{7{ir[8]}}, ir[8:0]};
         ea = pc_of[c] + off9;
         r.instruction_word = ir;
         case (op)
            OP_BR: begin
               if ((dr & nzp_of[c]) != 3'b000) pc_of[c] = ea;
            end
            OP_ADD, OP_AND, OP_NOT: begin
               a = gpr[c][sr1];
               b = ir[5] ? {{11{ir[4]}}, ir[4:0]} : gpr[c][sr2];
               if (op == OP_ADD) v = a + b;
               else if (op == OP_AND) v = a & b;
               else v = ~a;
               gpr[c][dr] = v;
               nzp_of[c] = (v == 16'h0000) ? FLAG_Z : (v[15] ? FLAG_N : FLAG_P);
               r.reg_written = 1'b1;
               r.reg_index = dr;
               r.reg_value = v;
            end
            OP_LD: begin
               v = word_store[c][ea];
               gpr[c][dr] = v;
               r.reg_written = 1'b1;
               r.reg_index = dr;
               r.reg_value = v;
            end
            OP_ST: begin
               word_store[c][ea] = gpr[c][dr];
               r.mem_written = 1'b1;
               r.mem_address = ea;
               r.mem_value = gpr[c][dr];
            end
            OP_JMP: begin
               pc_of[c] = gpr[c][sr1];
            end
            OP_TRAP: begin
               v = word_store[c][{8'h00, ir[7:0]}];
               gpr[c][TRAP_LINK_REG] = pc_of[c];
               r.reg_written = 1'b1;
               r.reg_index = TRAP_LINK_REG;
               r.reg_value = pc_of[c];
               pc_of[c] = v;
            end
            default: begin
               // unsupported opcode: fetch and PC bump only
            end
         endcase
      end
      r.next_pc = pc_of[c];
      r.cond_flags = nzp_of[c];
      return r;
   endfunction

   // Append a request to the feed, advancing the plan copy so that the
   // program builder always knows where PC will be and which words hold data.
   function automatic void queue_request(kind_type k, logic [15:0] addr, logic [15:0] data);
      item_type   it;
      result_type r;
      it.kind = k;
      it.address = addr;
      it.data = data;
      if (k == KIND_WRITE) word_loaded[addr] = 1'b1;
      r = lc3_effect(PLAN, it);
      if (r.mem_written) word_loaded[r.mem_address] = 1'b1;
      program_feed.push_back(it);
   endfunction

   // Execute one instruction at the planned PC. Either write a new word there
   // or reuse what already sits there; make sure any word that LD or TRAP
   // reads has been written first, so no undefined word is ever read.
   function automatic void run_instruction(bit fresh, logic [15:0] word);
      logic [15:0] at, ir, target;
      bit          reads;
      at = pc_of[PLAN];
      if (fresh || !word_loaded[at]) queue_request(KIND_WRITE, at, word);
      ir = word_store[PLAN][at];
      reads = 1'b1;
      target = 16'h0000;
      case (ir[15:12])
         OP_LD:   target = at + 16'd1 + {{7{ir[8]}}, ir[8:0]};
         OP_TRAP: target = {8'h00, ir[7:0]};
         default: reads = 1'b0;
      endcase
      if (reads && !word_loaded[target]) queue_request(KIND_WRITE, target, 16'($urandom));
      queue_request(KIND_STEP, 16'($urandom), 16'($urandom));
   endfunction

   // Random instruction word, leaning towards the supported opcodes.
   function automatic logic [15:0] random_instruction();
      int unsigned sel;
      logic [3:0]  op;
      sel = $urandom_range(0, 23);
      case (sel)
         16, 17:  op = OP_ADD;
         18:      op = OP_AND;
         19:      op = OP_NOT;
         20, 21:  op = OP_BR;
         22:      op = OP_LD;
         23:      op = OP_ST;
         default: op = 4'(sel);
      endcase
      return {op, 12'($urandom)};
   endfunction

   function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected %h, got %h", name, want, got);
         failures++;
      end
   endfunction

   // Driver: present the head of the feed at the falling edge. Hold an offer
   // that was not taken; otherwise idle at random, pause once for a full
   // drain, and advance to the next request.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !handed_over) begin
         // hold the stalled request unchanged
      end else if (program_feed.size() == 0
                   || (requests_taken == PAUSE_AT && effects_due.size() != 0)
                   || (!quiet_stretch && $urandom_range(0, 99) < 25)) begin
         req_valid <= 1'b0;
      end else begin
         req_valid <= 1'b1;
         req_command <= program_feed[0].kind;
         req_load_address <= program_feed[0].address;
         req_load_data <= program_feed[0].data;
      end
   end

   // Receiver stall: random, with one long hold-off counted here so that the
   // front queue fills and the block stalls its input.
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (!hold_done && results_seen >= HOLD_AT) begin
         rsp_stall <= 1'b1;
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else begin
         rsp_stall <= !quiet_stretch && ($urandom_range(0, 99) < 25);
      end
   end

   // Monitor: at the rising edge check a delivered result against the oldest
   // predicted effect, then record a request taken in the same edge.
   always @(posedge clock) begin
      item_type   taken;
      result_type want;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (effects_due.size() == 0) begin
               $error("result delivered with no request outstanding");
               failures++;
            end else begin
               want = effects_due.pop_front();
               check_field("next_pc", want.next_pc, rsp_next_pc);
               check_field("instruction_word", want.instruction_word, rsp_instruction_word);
               check_field("reg_written", 16'(want.reg_written), 16'(rsp_reg_written));
               check_field("reg_index", 16'(want.reg_index), 16'(rsp_reg_index));
               check_field("reg_value", want.reg_value, rsp_reg_value);
               check_field("mem_written", 16'(want.mem_written), 16'(rsp_mem_written));
               check_field("mem_address", want.mem_address, rsp_mem_address);
               check_field("mem_value", want.mem_value, rsp_mem_value);
               check_field("cond_flags", 16'(want.cond_flags), 16'(rsp_cond_flags));
            end
         end
         handed_over <= req_valid && !req_stall;
         if (req_valid && !req_stall) begin
            // predict from what was actually driven on the ports
            taken.kind = kind_type'(req_command);
            taken.address = req_load_address;
            taken.data = req_load_data;
            effects_due.push_back(lc3_effect(LIVE, taken));
            void'(program_feed.pop_front());
            requests_taken++;
         end
      end
   end

   initial begin
      for (int c = 0; c < 2; c++) begin
         pc_of[c] = 16'h0000;
         nzp_of[c] = FLAG_Z;
         for (int i = 0; i < NUM_REGS; i++) gpr[c][i] = 16'h0000;
      end

      // Directed opening: field extremes, every supported opcode, the special cases.
      queue_request(KIND_WRITE, 16'hFFFF, 16'hFFFF);
      queue_request(KIND_WRITE, 16'h0000, 16'h0000);
      run_instruction(1'b1, {OP_ADD, 3'd1, 3'd0, 1'b1, 5'h0F});        // R1 = 15
      run_instruction(1'b1, {OP_ADD, 3'd2, 3'd1, 1'b1, 5'h10});        // R2 = -1, n
      run_instruction(1'b1, {OP_AND, 3'd3, 3'd2, 3'b000, 3'd1});       // register operand
      run_instruction(1'b1, {OP_NOT, 3'd4, 3'd2, 6'h3F});              // zero result, z
      run_instruction(1'b1, {OP_NOT, 3'd5, 3'd1, 6'h00});              // NOT with odd low bits
      run_instruction(1'b1, {OP_BR, 3'b010, 9'h005});                  // not taken
      run_instruction(1'b1, {OP_BR, 3'b111, 9'h100});                  // taken, PC wraps down
      run_instruction(1'b1, {OP_LD, 3'd6, 9'h1FF});                    // loads its own word
      run_instruction(1'b1, {OP_ST, 3'd2, 9'h000});
      run_instruction(1'b1, {OP_JMP, 3'd0, 3'd2, 6'h00});              // PC = FFFF
      run_instruction(1'b0, 16'h0000);                                 // top word: TRAP xFF
      run_instruction(1'b1, {OP_TRAP, 4'h0, 8'h25});
      run_instruction(1'b1, {OP_UNUSED, 12'h123});

      // Random part: mostly whole instructions, some stale words and noise writes.
      while (program_feed.size() < FEED_TARGET) begin
         case ($urandom_range(0, 7))
            0:       queue_request(KIND_WRITE, 16'($urandom), 16'($urandom));
            1:       run_instruction(1'b0, random_instruction());
            default: run_instruction(1'b1, random_instruction());
         endcase
      end

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (program_feed.size() != 0 || effects_due.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      if (failures == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
